>>> rtl/cbms_pkg.sv
// ----------------------------------------------------------------------------
// cbms_pkg
// Shared types and constants for the cell balance mask select block.
// ----------------------------------------------------------------------------
package cbms_pkg;

    localparam int VALUE_W = 16;
    localparam int MASK_W  = 12;
    localparam int LIMIT_W = VALUE_W + 1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_STOP   = 1'b1;

    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 16'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_SCAN,
        ST_DRAIN,
        ST_LOAD,
        ST_STOP
    } state_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cmp_ctrl_t;

endpackage

>>> rtl/cell_balance_mask_select_core.sv
// ----------------------------------------------------------------------------
// cell_balance_mask_select_core
// Passive balancing mask selection: cells above pack minimum plus threshold.
// ----------------------------------------------------------------------------
// A cell sample request is taken and stored; min and max are tracked on
// the fly. The last cell of the pack starts the mask pass: a setup step,
// then per device a scan that walks the cell store through its single
// read port and the shared comparator, plus a drain and a load step; the
// load step waits until the output register is free. A stop request sends
// a zero mask for each device. The block is not ready during a pass or a
// stop; a finished result waits in the output register while the next
// samples load.
// ----------------------------------------------------------------------------
module cell_balance_mask_select_core #(
    parameter int NUM_DEVICES      = 2,
    parameter int CELLS_PER_DEVICE = 12
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_cell_value,
    input  logic        s_overtemp_pause,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_device_index,
    output logic [11:0] m_discharge_mask,
    output logic [15:0] m_spread,
    output logic        m_balanced,
    output logic        m_drive_write,
    output logic        m_last_result
);

    localparam int TOTAL = NUM_DEVICES * CELLS_PER_DEVICE;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int CPW   = (CELLS_PER_DEVICE > 1) ? $clog2(CELLS_PER_DEVICE) : 1;
    localparam int DW    = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int MW    = (CELLS_PER_DEVICE > cbms_pkg::MASK_W) ?
                           CELLS_PER_DEVICE : cbms_pkg::MASK_W;
    localparam int VW    = cbms_pkg::VALUE_W;
    localparam int LW    = cbms_pkg::LIMIT_W;

    cbms_pkg::state_t state_reg, state_next;

    logic [VW-1:0]  thr_reg, thr_next;
    logic [AW-1:0]  count_reg, count_next;
    logic [VW-1:0]  min_reg, min_next;
    logic [VW-1:0]  max_reg, max_next;
    logic [LW-1:0]  limit_reg, limit_next;
    logic [VW-1:0]  spread_reg, spread_next;
    logic           bal_reg, bal_next;
    logic           wr_reg, wr_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [CPW-1:0] cell_reg, cell_next;
    logic [DW-1:0]  dev_reg, dev_next;
    logic           rd_pending_reg, rd_pending_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_dev_reg, m_dev_next;
    logic [cbms_pkg::MASK_W-1:0] m_mask_reg, m_mask_next;
    logic [VW-1:0]              m_spread_reg, m_spread_next;
    logic                       m_bal_reg, m_bal_next;
    logic                       m_wr_reg, m_wr_next;
    logic                       m_last_reg, m_last_next;

    logic                    in_acc;
    logic                    out_free;
    logic                    last_cell;
    logic                    cell_last;
    logic                    dev_last;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [VW-1:0]           ram_rd_data;
    logic [VW-1:0]           spread_calc;
    logic [CELLS_PER_DEVICE-1:0] dev_mask;
    logic [MW-1:0]           mask_wide;
    cbms_pkg::cmp_ctrl_t     cmp_ctrl;

    assign s_ready   = (state_reg == cbms_pkg::ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_cell = (count_reg == AW'(TOTAL - 1));
    assign cell_last = (cell_reg == CPW'(CELLS_PER_DEVICE - 1));
    assign dev_last  = (dev_reg == DW'(NUM_DEVICES - 1));
    assign spread_calc = max_reg - min_reg;
    assign mask_wide   = MW'(dev_mask);
    assign ram_wr_en   = in_acc && (s_kind == cbms_pkg::KIND_SAMPLE);
    assign ram_rd_en   = (state_reg == cbms_pkg::ST_SCAN);

    cbms_cell_ram #(
        .DEPTH  (TOTAL),
        .ADDR_W (AW)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg),
        .wr_data (s_cell_value),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    cbms_cmp_unit #(
        .CELLS (CELLS_PER_DEVICE)
    ) u_cmp_unit (
        .aclk    (aclk),
        .ctrl    (cmp_ctrl),
        .rd_data (ram_rd_data),
        .limit   (limit_reg),
        .mask    (dev_mask)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cbms_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_kind == cbms_pkg::KIND_STOP) begin
                        state_next = cbms_pkg::ST_STOP;
                    end else if (last_cell) begin
                        state_next = cbms_pkg::ST_CALC;
                    end
                end
            end
            cbms_pkg::ST_CALC: begin
                state_next = cbms_pkg::ST_SCAN;
            end
            cbms_pkg::ST_SCAN: begin
                if (cell_last) begin
                    state_next = cbms_pkg::ST_DRAIN;
                end
            end
            cbms_pkg::ST_DRAIN: begin
                state_next = cbms_pkg::ST_LOAD;
            end
            cbms_pkg::ST_LOAD: begin
                if (out_free) begin
                    state_next = dev_last ? cbms_pkg::ST_IDLE : cbms_pkg::ST_SCAN;
                end
            end
            cbms_pkg::ST_STOP: begin
                if (out_free && dev_last) begin
                    state_next = cbms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbms_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        thr_next        = cfg_wr_en ? cfg_wr_data : thr_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        limit_next      = limit_reg;
        spread_next     = spread_reg;
        bal_next        = bal_reg;
        wr_next         = wr_reg;
        addr_next       = addr_reg;
        cell_next       = cell_reg;
        dev_next        = dev_reg;
        rd_pending_next = (state_reg == cbms_pkg::ST_SCAN);
        cmp_ctrl.clear  = 1'b0;
        cmp_ctrl.shift  = rd_pending_reg;

        m_valid_next  = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_dev_next    = m_dev_reg;
        m_mask_next   = m_mask_reg;
        m_spread_next = m_spread_reg;
        m_bal_next    = m_bal_reg;
        m_wr_next     = m_wr_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            cbms_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (s_kind == cbms_pkg::KIND_STOP) begin
                        min_next   = '1;
                        max_next   = '0;
                        count_next = '0;
                        dev_next   = '0;
                    end else begin
                        if (s_cell_value < min_reg) begin
                            min_next = s_cell_value;
                        end
                        if (s_cell_value > max_reg) begin
                            max_next = s_cell_value;
                        end
                        if (last_cell) begin
                            count_next = '0;
                            wr_next    = !s_overtemp_pause;
                        end else begin
                            count_next = count_reg + AW'(1);
                        end
                    end
                end
            end
            cbms_pkg::ST_CALC: begin
                limit_next     = {1'b0, min_reg} + {1'b0, thr_reg};
                spread_next    = spread_calc;
                bal_next       = (spread_calc < thr_reg);
                min_next       = '1;
                max_next       = '0;
                addr_next      = '0;
                cell_next      = '0;
                dev_next       = '0;
                cmp_ctrl.clear = 1'b1;
            end
            cbms_pkg::ST_SCAN: begin
                addr_next = addr_reg + AW'(1);
                cell_next = cell_last ? '0 : cell_reg + CPW'(1);
            end
            cbms_pkg::ST_DRAIN: begin
            end
            cbms_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_dev_next     = dev_reg[0];
                    m_mask_next    = mask_wide[cbms_pkg::MASK_W-1:0];
                    m_spread_next  = spread_reg;
                    m_bal_next     = bal_reg;
                    m_wr_next      = wr_reg;
                    m_last_next    = dev_last;
                    dev_next       = dev_reg + DW'(1);
                    cmp_ctrl.clear = 1'b1;
                end
            end
            cbms_pkg::ST_STOP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_dev_next    = dev_reg[0];
                    m_mask_next   = '0;
                    m_spread_next = '0;
                    m_bal_next    = 1'b0;
                    m_wr_next     = 1'b1;
                    m_last_next   = dev_last;
                    dev_next      = dev_reg + DW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= cbms_pkg::ST_IDLE;
            thr_reg        <= cbms_pkg::THRESHOLD_RESET;
            count_reg      <= '0;
            min_reg        <= '1;
            max_reg        <= '0;
            addr_reg       <= '0;
            cell_reg       <= '0;
            dev_reg        <= '0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            count_reg      <= count_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            addr_reg       <= addr_next;
            cell_reg       <= cell_next;
            dev_reg        <= dev_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        spread_reg   <= spread_next;
        bal_reg      <= bal_next;
        wr_reg       <= wr_next;
        m_dev_reg    <= m_dev_next;
        m_mask_reg   <= m_mask_next;
        m_spread_reg <= m_spread_next;
        m_bal_reg    <= m_bal_next;
        m_wr_reg     <= m_wr_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_device_index   = m_dev_reg;
    assign m_discharge_mask = m_mask_reg;
    assign m_spread         = m_spread_reg;
    assign m_balanced       = m_bal_reg;
    assign m_drive_write    = m_wr_reg;
    assign m_last_result    = m_last_reg;

    // more device results still to come, so the sequencer must be busy
    a_busy_until_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_result) |-> (state_reg != cbms_pkg::ST_IDLE))
        else $error("sequencer idle before last result");

    a_stop_clears_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cbms_pkg::ST_STOP) |-> (count_reg == '0 && min_reg == '1))
        else $error("stop did not discard partial run");

    a_read_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pending_reg |-> (state_reg == cbms_pkg::ST_SCAN ||
                            state_reg == cbms_pkg::ST_DRAIN))
        else $error("cell read data outside mask pass");

endmodule

>>> rtl/cbms_cell_ram.sv
// ----------------------------------------------------------------------------
// cbms_cell_ram
// Cell value store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cbms_cell_ram #(
    parameter int DEPTH  = 24,
    parameter int ADDR_W = 5
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cbms_pkg::VALUE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cbms_pkg::VALUE_W-1:0] rd_data
);

    logic [cbms_pkg::VALUE_W-1:0] mem [0:DEPTH-1];
    logic [cbms_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/cbms_cmp_unit.sv
// ----------------------------------------------------------------------------
// cbms_cmp_unit
// Shared compare against minimum plus threshold, shifting one mask bit per cell.
// ----------------------------------------------------------------------------
module cbms_cmp_unit #(
    parameter int CELLS = 12
) (
    input  logic                          aclk,
    input  cbms_pkg::cmp_ctrl_t           ctrl,
    input  logic [cbms_pkg::VALUE_W-1:0]  rd_data,
    input  logic [cbms_pkg::LIMIT_W-1:0]  limit,
    output logic [CELLS-1:0]              mask
);

    logic             above;
    logic [CELLS-1:0] mask_reg;
    logic [CELLS-1:0] mask_next;
    logic [CELLS-1:0] shifted;

    assign above = {1'b0, rd_data} > limit;

    generate
        if (CELLS > 1) begin : g_multi
            assign shifted = {above, mask_reg[CELLS-1:1]};
        end else begin : g_single
            assign shifted = above;
        end
    endgenerate

    always_comb begin
        mask_next = mask_reg;
        if (ctrl.clear) begin
            mask_next = '0;
        end else if (ctrl.shift) begin
            mask_next = shifted;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
    end

    assign mask = mask_reg;

endmodule
